// ===== design/gbce_pkg.sv =====
// Shared types, constants and round functions of the GOST block cipher engine.
package gbce_pkg;

	localparam int NUM_ROUNDS = 32;
	localparam int ROUND_W    = 5;
	localparam int KEY_WORDS  = 8;
	localparam int KEY_IDX_W  = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int WORD_W     = 32;
	localparam int ROT_AMT    = 11;

	// Rounds at which the key order turns from ascending to descending
	localparam logic [ROUND_W-1:0] ENC_TURN = ROUND_W'(24);
	localparam logic [ROUND_W-1:0] DEC_TURN = ROUND_W'(8);

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	typedef struct packed {
		logic              decrypt;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} blk_t;

	// Row n substitutes nibble n
	localparam logic [7:0][15:0][3:0] SBOX = '{
		'{4'h1, 4'hf, 4'hd, 4'h0, 4'h5, 4'h7, 4'ha, 4'h4,
		  4'h9, 4'h2, 4'h3, 4'he, 4'h6, 4'hb, 4'h8, 4'hc},
		'{4'hd, 4'hb, 4'h4, 4'h1, 4'h3, 4'hf, 4'h5, 4'h9,
		  4'h0, 4'ha, 4'he, 4'h7, 4'h6, 4'h8, 4'h2, 4'hc},
		'{4'h4, 4'hb, 4'ha, 4'h0, 4'h7, 4'h2, 4'h1, 4'hd,
		  4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hc, 4'hf, 4'he},
		'{4'h6, 4'hc, 4'h7, 4'h1, 4'h5, 4'hf, 4'hd, 4'h8,
		  4'h4, 4'ha, 4'h9, 4'he, 4'h0, 4'h3, 4'hb, 4'h2},
		'{4'h7, 4'hd, 4'ha, 4'h1, 4'h0, 4'h8, 4'h9, 4'hf,
		  4'he, 4'h4, 4'h6, 4'hc, 4'hb, 4'h2, 4'h5, 4'h3},
		'{4'h5, 4'h8, 4'h1, 4'hd, 4'ha, 4'h3, 4'h4, 4'h2,
		  4'he, 4'hf, 4'hc, 4'h7, 4'h6, 4'h0, 4'h9, 4'hb},
		'{4'he, 4'hb, 4'h4, 4'hc, 4'h6, 4'hd, 4'hf, 4'ha,
		  4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
		'{4'h4, 4'ha, 4'h9, 4'h2, 4'hd, 4'h8, 4'h0, 4'he,
		  4'h6, 4'hb, 4'h1, 4'hc, 4'h7, 4'hf, 4'h5, 4'h3}
	};

	// Substitute every nibble, then rotate left
	function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = '0;
		for (int n = 0; n < 8; n++) begin
			s[4*n +: 4] = SBOX[n][15 - int'(v[4*n +: 4])];
		end
		return {s[WORD_W-ROT_AMT-1:0], s[WORD_W-1:WORD_W-ROT_AMT]};
	endfunction

	// Key word used by a round: ascending passes, then one descending pass or three
	function automatic logic [KEY_IDX_W-1:0] key_index(input logic decrypt,
			input logic [ROUND_W-1:0] rnd);
		logic [KEY_IDX_W-1:0] low;
		logic                 fwd;
		low = rnd[KEY_IDX_W-1:0];
		fwd = decrypt ? (rnd < DEC_TURN) : (rnd < ENC_TURN);
		return fwd ? low : ~low;
	endfunction

endpackage

// ===== design/gbce_round_cell.sv =====
// One Feistel round of the cipher with its stage register and valid bit.
module gbce_round_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [gbce_pkg::ROUND_W-1:0] round_idx,
	input  gbce_pkg::key_t               key,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  gbce_pkg::blk_t               up_blk,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output gbce_pkg::blk_t               dn_blk
);
	import gbce_pkg::*;

	logic              valid_q;
	blk_t              blk_q;
	logic [WORD_W-1:0] sum;
	logic              load;

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;
	assign sum      = up_blk.left + key[key_index(up_blk.decrypt, round_idx)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Swap halves while loading
	always_ff @(posedge clk) begin
		if (load) begin
			blk_q.decrypt <= up_blk.decrypt;
			blk_q.left    <= up_blk.right ^ round_f(sum);
			blk_q.right   <= up_blk.left;
		end
	end

	assign dn_valid = valid_q;
	assign dn_blk   = blk_q;

endmodule

// ===== design/gost_block_cipher_engine_core.sv =====
// Top level: key registers and a chain of 32 round cells.
// An accepted input passes through every round cell register, in order, to reach out_valid.
// Throughput: one block per cycle while out_stall is low; every round has its own cell register.
// A cell frees up as soon as the one after it takes its block, so stall
// propagates back only when the whole chain is full.
// Reset (arst_n low) clears all cell valid bits and the eight key words to zero.
module gost_block_cipher_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gbce_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gbce_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [gbce_pkg::WORD_W-1:0]    block_left,
	input  logic [gbce_pkg::WORD_W-1:0]    block_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gbce_pkg::WORD_W-1:0]    out_left,
	output logic [gbce_pkg::WORD_W-1:0]    out_right
);
	import gbce_pkg::*;

	key_t                key_q;
	logic [NUM_ROUNDS:0] vld;
	logic [NUM_ROUNDS:0] rdy;
	blk_t                blk [NUM_ROUNDS+1];

	// Key words: indexes past the last word drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_idx[KEY_IDX_W-1:0]] <= cfg_wdata;
		end
	end

	// Head of the chain takes the request
	assign vld[0]          = in_valid;
	assign blk[0].decrypt  = req_type;
	assign blk[0].left     = block_left;
	assign blk[0].right    = block_right;
	assign in_stall        = !rdy[0];

	// One cell per round; each hands its block to the next every cycle it can
	for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
		gbce_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.round_idx (ROUND_W'(i)),
			.key       (key_q),
			.up_valid  (vld[i]),
			.up_ready  (rdy[i]),
			.up_blk    (blk[i]),
			.dn_valid  (vld[i+1]),
			.dn_ready  (rdy[i+1]),
			.dn_blk    (blk[i+1])
		);
	end

	// The last cell register is the output register; undo the final swap
	assign rdy[NUM_ROUNDS] = !out_stall;
	assign out_valid       = vld[NUM_ROUNDS];
	assign out_left        = blk[NUM_ROUNDS].right;
	assign out_right       = blk[NUM_ROUNDS].left;

`ifndef NO_ASSERTIONS
	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld[1])
		else $error("accepted transaction did not reach the first cell");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld[NUM_ROUNDS:1]))
		else $error("input stalled while a cell was empty");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx < CFG_IDX_W'(KEY_WORDS))) |=>
		(key_q[$past(cfg_idx[KEY_IDX_W-1:0])] == $past(cfg_wdata)))
		else $error("key word write lost");

	a_out_hold_keeps_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("waiting result dropped");
`endif

endmodule
